@@ rtl/core/wdc_pkg.sv @@
// Shared types and constants of the winchester disk register controller.
// Used by the sector buffer and the top level; depends on nothing else.
`timescale 1ns / 1ps

package wdc_pkg;

	// Fixed geometry of the buffer and of the drive table
	localparam int SECTOR_BYTES = 256;
	localparam int IDX_W        = $clog2(SECTOR_BYTES);
	localparam int DRIVE_COUNT  = 2;

	// Host bus access codes
	typedef enum logic [3:0] {
		OP_RD_STATUS = 4'd0,
		OP_RD_ERROR  = 4'd1,
		OP_RD_DATA   = 4'd2,
		OP_WR_SECTOR = 4'd3,
		OP_WR_CYL_LO = 4'd4,
		OP_WR_CYL_HI = 4'd5,
		OP_WR_SDH    = 4'd6,
		OP_WR_CMD    = 4'd7,
		OP_WR_DATA   = 4'd8,
		OP_MEDIA_FILL = 4'd9
	} wdc_op_t;

	// Command codes, taken from the high nibble of the command byte
	localparam logic [3:0] CMD_RESTORE = 4'h1;
	localparam logic [3:0] CMD_READ    = 4'h2;
	localparam logic [3:0] CMD_WRITE   = 4'h3;
	localparam logic [3:0] CMD_SEEK    = 4'h7;

	// Transfer phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_DRQ     = 2'd1,
		PH_WRITING = 2'd2
	} wdc_phase_t;

	// Status and error register values
	localparam logic [7:0] ST_NO_MEDIUM = 8'hFF;
	localparam logic [7:0] ST_DRQ       = 8'h58;
	localparam logic [7:0] ST_READY     = 8'h50;
	localparam logic [7:0] ERR_NONE     = 8'h00;
	localparam logic [7:0] DATA_IDLE    = 8'hFF;

	// Activity indicator values
	localparam logic [2:0] ACT_BUSY = 3'd6;
	localparam logic [2:0] ACT_SEEK = 3'd3;

	// Register index on the configuration port
	localparam logic REG_DRIVE_PRESENT = 1'b0;

	// One result word
	typedef struct packed {
		logic [2:0]  activity;
		logic [2:0]  last_head_out;
		logic [15:0] last_cylinder;
		logic        media_fault;
		logic        media_drive;
		logic [15:0] media_lba;
		logic        media_request;
		logic [7:0]  read_byte;
	} wdc_result_t;

	// Result waiting for the sector buffer read data
	typedef struct packed {
		wdc_result_t res;
		logic        use_buf;
		logic        buf_zero;
	} wdc_stage_t;

endpackage

@@ rtl/core/wdc_sbuf.sv @@
// Sector buffer of the winchester disk register controller.
// One write port and one read port with registered read data; uses wdc_pkg.
`timescale 1ns / 1ps

module wdc_sbuf (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [wdc_pkg::IDX_W-1:0] wr_addr,
	input  logic [7:0]              wr_data,
	input  logic                    rd_en,
	input  logic [wdc_pkg::IDX_W-1:0] rd_addr,
	output logic [7:0]              rd_data
);

	logic [7:0] mem [wdc_pkg::SECTOR_BYTES];

	// Media fill writes one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data is held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/winchester_disk_register_controller.sv @@
// Top level of the winchester disk register controller: host register file,
// command decode, drive table and result pipeline. Uses wdc_pkg and wdc_sbuf.
`timescale 1ns / 1ps

// Each input word is one host bus access (status, error or data read; sector,
// cylinder, SDH, command or data write; media fill of one buffer byte) and
// gives exactly one result word. The block takes one word per cycle unless
// both result stages are full: all register state is updated in the cycle a
// word is accepted, and a data read fetches its byte from the 256-byte sector
// buffer through its registered read port. Each result is held in the s1 stage,
// where buffer data joins it, and then in the output register. A result held
// by a stalled output and one waiting for buffer data
// can be parked at the same time; input is refused only when both are full.
// The read command computes cylinder*heads*sectors + head*sectors + sector
// in the accept cycle. The drive_present register sits at byte address 0 of
// the configuration port and should be written only while the block is idle.
module winchester_disk_register_controller #(
	parameter int HEADS_PER_CYLINDER = 6,
	parameter int SECTORS_PER_TRACK  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] opcode, [11:4] data_byte, [19:12] fill_index, [23:20] zero
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] read_byte, [8] media_request, [24:9] media_lba, [25] media_drive,
	// [26] media_fault, [42:27] last_cylinder, [45:43] last_head_out,
	// [48:46] activity, [55:49] zero
	output logic [55:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int GEOM      = HEADS_PER_CYLINDER * SECTORS_PER_TRACK;
	localparam int LBA_W     = 17 + $clog2(GEOM);
	localparam logic [LBA_W-1:0] LBA_LIMIT = LBA_W'(255 * GEOM);
	localparam logic [LBA_W-1:0] GEOM_K    = LBA_W'(GEOM);
	localparam logic [LBA_W-1:0] SPT_K     = LBA_W'(SECTORS_PER_TRACK);

	// Register state
	logic [1:0]               drive_present_q;
	logic [7:0]               cyl_lo_q, cyl_hi_q;
	logic [4:0]               sector_q;
	logic [7:0]               sdh_q;
	wdc_pkg::wdc_phase_t      phase_q, phase_d;
	logic [wdc_pkg::IDX_W-1:0] byte_idx_q;
	logic                     sector_fault_q;
	logic [15:0]              drv_cyl_q  [wdc_pkg::DRIVE_COUNT];
	logic [2:0]               drv_head_q [wdc_pkg::DRIVE_COUNT];
	logic [2:0]               drv_act_q  [wdc_pkg::DRIVE_COUNT];

	// Next values
	logic [7:0]               cyl_lo_d, cyl_hi_d, sdh_d;
	logic [4:0]               sector_d;
	logic [wdc_pkg::IDX_W-1:0] byte_idx_d;
	logic                     sector_fault_d;
	logic                     pos_en;
	logic [15:0]              pos_cyl;
	logic [2:0]               pos_act;

	// Pipeline
	logic                     s1_valid_q, out_valid_q;
	wdc_pkg::wdc_stage_t      s1_q, s1_d;
	wdc_pkg::wdc_result_t     out_q, out_d;
	logic [7:0]               buf_rdata;

	// Decode of the current word
	wdc_pkg::wdc_op_t         op;
	logic [7:0]               din;
	logic [wdc_pkg::IDX_W-1:0] fidx;
	logic                     in_acc, out_free, s1_move;
	logic                     drv, drv_new, present;
	logic                     idx_wrap, data_rd;
	logic [15:0]              cur_cyl;
	logic [LBA_W-1:0]         lba;
	logic                     lba_fault;

	assign op   = wdc_pkg::wdc_op_t'(s_axis_tdata[3:0]);
	assign din  = s_axis_tdata[11:4];
	assign fidx = s_axis_tdata[19:12];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_move       = s1_valid_q && out_free;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign drv      = sdh_q[3];
	assign present  = drive_present_q[drv];
	assign idx_wrap = (byte_idx_q == {wdc_pkg::IDX_W{1'b1}});
	assign data_rd  = in_acc && (op == wdc_pkg::OP_RD_DATA) && (phase_q == wdc_pkg::PH_DRQ);
	assign cur_cyl  = {cyl_hi_q, cyl_lo_q};

	// Logical block address of the current cylinder, head and sector
	assign lba = LBA_W'(cur_cyl) * GEOM_K + LBA_W'(sdh_q[2:0]) * SPT_K + LBA_W'(sector_q);
	assign lba_fault = !present || (lba >= LBA_LIMIT);

	// Phase: next state
	always_comb begin
		phase_d = phase_q;
		if (in_acc) begin
			case (op)
				wdc_pkg::OP_RD_DATA: begin
					if (phase_q == wdc_pkg::PH_DRQ && idx_wrap) begin
						phase_d = wdc_pkg::PH_IDLE;
					end
				end
				wdc_pkg::OP_WR_DATA: begin
					if (phase_q == wdc_pkg::PH_WRITING && idx_wrap) begin
						phase_d = wdc_pkg::PH_IDLE;
					end
				end
				wdc_pkg::OP_WR_CMD: begin
					case (din[7:4])
						wdc_pkg::CMD_RESTORE: phase_d = wdc_pkg::PH_IDLE;
						wdc_pkg::CMD_READ:    phase_d = wdc_pkg::PH_DRQ;
						wdc_pkg::CMD_WRITE:   phase_d = wdc_pkg::PH_WRITING;
						wdc_pkg::CMD_SEEK:    phase_d = wdc_pkg::PH_IDLE;
						default:              phase_d = phase_q;
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Register updates and the result of the current word
	always_comb begin
		cyl_lo_d       = cyl_lo_q;
		cyl_hi_d       = cyl_hi_q;
		sector_d       = sector_q;
		sdh_d          = sdh_q;
		byte_idx_d     = byte_idx_q;
		sector_fault_d = sector_fault_q;
		pos_en         = 1'b0;
		pos_cyl        = cur_cyl;
		pos_act        = wdc_pkg::ACT_BUSY;
		s1_d           = '0;
		case (op)
			wdc_pkg::OP_RD_STATUS: begin
				if (!present) begin
					s1_d.res.read_byte = wdc_pkg::ST_NO_MEDIUM;
				end else if (phase_q == wdc_pkg::PH_DRQ || phase_q == wdc_pkg::PH_WRITING) begin
					s1_d.res.read_byte = wdc_pkg::ST_DRQ;
				end else begin
					s1_d.res.read_byte = wdc_pkg::ST_READY;
				end
			end
			wdc_pkg::OP_RD_ERROR: s1_d.res.read_byte = wdc_pkg::ERR_NONE;
			wdc_pkg::OP_RD_DATA: begin
				if (phase_q == wdc_pkg::PH_DRQ) begin
					s1_d.use_buf  = 1'b1;
					s1_d.buf_zero = sector_fault_q;
					byte_idx_d    = byte_idx_q + 1'b1;
				end else begin
					s1_d.res.read_byte = wdc_pkg::DATA_IDLE;
				end
			end
			wdc_pkg::OP_WR_SECTOR: sector_d = din[4:0];
			wdc_pkg::OP_WR_CYL_LO: cyl_lo_d = din;
			wdc_pkg::OP_WR_CYL_HI: cyl_hi_d = din;
			wdc_pkg::OP_WR_SDH:    sdh_d    = din;
			wdc_pkg::OP_WR_CMD: begin
				case (din[7:4])
					wdc_pkg::CMD_RESTORE: begin
						cyl_lo_d   = '0;
						cyl_hi_d   = '0;
						byte_idx_d = '0;
						pos_en     = 1'b1;
						pos_cyl    = '0;
					end
					wdc_pkg::CMD_READ: begin
						s1_d.res.media_request = 1'b1;
						s1_d.res.media_lba     = lba[15:0];
						s1_d.res.media_fault   = lba_fault;
						sector_fault_d         = lba_fault;
						byte_idx_d             = '0;
						pos_en                 = 1'b1;
					end
					wdc_pkg::CMD_WRITE: begin
						byte_idx_d = '0;
						pos_en     = 1'b1;
					end
					wdc_pkg::CMD_SEEK: begin
						pos_en  = 1'b1;
						pos_act = wdc_pkg::ACT_SEEK;
					end
					default: pos_en = 1'b0;
				endcase
			end
			wdc_pkg::OP_WR_DATA: begin
				if (phase_q == wdc_pkg::PH_WRITING) begin
					byte_idx_d = byte_idx_q + 1'b1;
				end
			end
			default: s1_d.res.read_byte = '0;
		endcase

		// Drive table as seen after this access
		drv_new              = sdh_d[3];
		s1_d.res.media_drive = drv_new;
		if (pos_en && drv_new == drv) begin
			s1_d.res.last_cylinder = pos_cyl;
			s1_d.res.last_head_out = sdh_q[2:0];
			s1_d.res.activity      = pos_act;
		end else begin
			s1_d.res.last_cylinder = drv_cyl_q[drv_new];
			s1_d.res.last_head_out = drv_head_q[drv_new];
			s1_d.res.activity      = drv_act_q[drv_new];
		end
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_lo_q       <= '0;
			cyl_hi_q       <= '0;
			sector_q       <= '0;
			sdh_q          <= '0;
			phase_q        <= wdc_pkg::PH_IDLE;
			byte_idx_q     <= '0;
			sector_fault_q <= 1'b0;
			for (int i = 0; i < wdc_pkg::DRIVE_COUNT; i++) begin
				drv_cyl_q[i]  <= '0;
				drv_head_q[i] <= '0;
				drv_act_q[i]  <= '0;
			end
		end else if (in_acc) begin
			cyl_lo_q       <= cyl_lo_d;
			cyl_hi_q       <= cyl_hi_d;
			sector_q       <= sector_d;
			sdh_q          <= sdh_d;
			phase_q        <= phase_d;
			byte_idx_q     <= byte_idx_d;
			sector_fault_q <= sector_fault_d;
			if (pos_en) begin
				drv_cyl_q[drv]  <= pos_cyl;
				drv_head_q[drv] <= sdh_q[2:0];
				drv_act_q[drv]  <= pos_act;
			end
		end
	end

	// Sector buffer
	wdc_sbuf u_sbuf (
		.clk     (clk),
		.wr_en   (in_acc && op == wdc_pkg::OP_MEDIA_FILL),
		.wr_addr (fidx),
		.wr_data (din),
		.rd_en   (data_rd),
		.rd_addr (byte_idx_q),
		.rd_data (buf_rdata)
	);

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Buffer data joins the result on its way out
	always_comb begin
		out_d = s1_q.res;
		if (s1_q.use_buf) begin
			out_d.read_byte = s1_q.buf_zero ? 8'h00 : buf_rdata;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_q <= s1_d;
		end
		if (s1_move) begin
			out_q <= out_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q};

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_present_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == wdc_pkg::REG_DRIVE_PRESENT) begin
			drive_present_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == wdc_pkg::REG_DRIVE_PRESENT) ? {30'b0, drive_present_q} : '0;

	// A waiting result is never overwritten while the output is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while both result stages are full");

	// A read command always leaves the block in data request
	a_read_drq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == wdc_pkg::OP_WR_CMD && din[7:4] == wdc_pkg::CMD_READ)
		|=> (phase_q == wdc_pkg::PH_DRQ && byte_idx_q == '0))
		else $error("read command did not open a data request");

	// A fault is only reported together with a media request
	a_fault_req: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.media_fault) |-> out_q.media_request)
		else $error("media fault without media request");

	// Buffer data of a clean read waits only for a free output stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free && s1_q.use_buf && !s1_q.buf_zero)
		|=> (s1_valid_q && $stable(buf_rdata)))
		else $error("pending buffer data lost");

endmodule
